[rtl/core/lfcg_pkg.sv]
// Shared types and constants for the LED frame color generator.
package lfcg_pkg;

  typedef enum logic [1:0] {
    OP_SET_MODE  = 2'd0,
    OP_SET_INDEX = 2'd1,
    OP_WR_TABLE  = 2'd2,
    OP_FRAME     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_PIXEL_COUNT = 2'd0,
    CFG_ENABLE      = 2'd1,
    CFG_MAX_STATE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MERGE = 2'd1,
    ST_FRAME = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_BLACK = 2'd1,
    KIND_SCALE = 2'd2
  } kind_e;

  localparam int unsigned CmdW   = 8;
  localparam int unsigned ColorW = 24;
  localparam int unsigned FacW   = 7;

  localparam logic [ColorW-1:0] WHITE           = 24'hFF_FFFF;
  localparam logic [FacW-1:0]   MAX_FACTOR      = 7'd64;
  localparam logic [6:0]        MAX_STATE_RESET = 7'd32;

  // channel * factor >> 5, clipped to a byte; factor 32 gives the channel back
  function automatic logic [7:0] scale_chan(input logic [7:0] ch, input logic [FacW-1:0] fac);
    logic [14:0] prod;
    logic [9:0]  shr;
    prod = ch * fac;
    shr  = prod[14:5];
    return (shr > 10'd255) ? 8'hFF : shr[7:0];
  endfunction

endpackage

[rtl/core/led_frame_color_generator.sv]
// Top level of the LED frame color generator: command store, color table, frame pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word per handshake. op_i
//   selects: set a pixel's mode bits, set a pixel's color index, write a color
//   table entry, or run a frame. The config port writes pixel_count, enable and
//   max_state_num with a single-cycle write strobe; write it only while idle.
//   Output channel (out_valid_o / out_ready_i) carries one GRB word per pixel,
//   last_o marking the final pixel of a frame.
// Timing:
//   Table write: lands on accept. Pixel mode/index write: read, merge, write back
//   through the command memory. Frame: each pixel passes the command memory
//   read, the color table read and the output register; the command memory read
//   port issues one pixel per cycle while the output is not stalled and sets the
//   rate. A frame while disabled or with pixel_count zero finishes at once, no words.
// Reset:
//   All pixels read as slow blink with color index 0, table entry 0 as white
//   and the rest as black (per-entry valid bits); pixel_count 0, enable 0,
//   max_state_num 32. No clearing pass is needed.
// Stall:
//   While the output register holds an untaken word, the whole frame pipeline
//   freezes, memory reads included. A new input word is accepted while the last
//   result still waits.
module led_frame_color_generator
  import lfcg_pkg::*;
#(
  parameter int unsigned MAX_PIXELS    = 64,
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [5:0]  pixel_index_i,
  input  logic [2:0]  mode_bits_i,
  input  logic [4:0]  color_index_i,
  input  logic [23:0] color_i,
  input  logic [5:0]  phase_i,
  input  logic        fade_fast_dec_i,
  input  logic        fade_slow_dec_i,
  input  logic        blink_fast_on_i,
  input  logic        blink_slow_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] pixel_word_o,
  output logic        last_o
);

  localparam int unsigned PixDepth = (MAX_PIXELS < 64) ? MAX_PIXELS : 64;
  localparam int unsigned PixAw    = (PixDepth > 1) ? $clog2(PixDepth) : 1;
  localparam int unsigned TblAw    = $clog2(TABLE_ENTRIES);

  // config registers
  logic [6:0] pixel_count_q, max_state_q;
  logic       enable_q;

  // control
  state_e     state_q, state_d;
  logic       accept, adv, issue, cnt_last;
  logic       cmd_re, cmd_we, tbl_we, frame_go, cmd_op_ok;
  logic [6:0] count_eff;
  logic [6:0] cnt_q, n_q;

  // latched item
  op_e        op_q;
  logic [PixAw-1:0] pix_q;
  logic [2:0] mode_q;
  logic [4:0] idx_q;
  logic [5:0] phase_q;
  logic       ffd_q, fsd_q, bfo_q, bso_q;

  // command memory
  logic [CmdW-1:0]  cmd_mem [PixDepth];
  logic [PixDepth-1:0] cmd_vld_q;
  logic [PixAw-1:0] cmd_raddr;
  logic [CmdW-1:0]  cmd_rdata_q, cmd_eff, cmd_merged;
  logic             cmd_rvld_q;

  // color table
  logic [ColorW-1:0] tbl_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tbl_vld_q;
  logic [ColorW-1:0] tbl_rdata_q, base_color;
  logic              tbl_rvld_q;
  logic [TblAw-1:0]  tbl_raddr;

  // pipeline
  logic        s1_v_q, s1_last_q;
  logic        s2_v_q, s2_last_q, s2_oor_q, s2_zero_q;
  kind_e       s2_kind_q, s1_kind;
  logic [FacW-1:0] s2_factor_q, s1_factor;
  logic        out_valid_q, out_last_q;
  logic [ColorW-1:0] out_word_q, out_word_d;

  // ---------------- config ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= '0;
      enable_q      <= 1'b0;
      max_state_q   <= MAX_STATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PIXEL_COUNT: pixel_count_q <= cfg_wdata_i;
        CFG_ENABLE:      enable_q      <= cfg_wdata_i[0];
        CFG_MAX_STATE:   max_state_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign count_eff = (pixel_count_q > 7'(PixDepth)) ? 7'(PixDepth) : pixel_count_q;
  assign adv       = !(out_valid_q && !out_ready_i);
  assign accept    = in_valid_i && in_ready_o;
  assign cmd_op_ok = ({1'b0, pixel_index_i} < 7'(PixDepth));
  assign cnt_last  = (cnt_q == n_q - 7'd1);
  assign frame_go  = accept && (op_e'(op_i) == OP_FRAME) && enable_q && (count_eff != '0);

  // ---------------- state machine ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((op_e'(op_i) == OP_SET_MODE || op_e'(op_i) == OP_SET_INDEX) && cmd_op_ok) begin
            state_d = ST_MERGE;
          end else if (frame_go) begin
            state_d = ST_FRAME;
          end
        end
      end
      ST_MERGE: state_d = ST_IDLE;
      ST_FRAME: begin
        if (issue && cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    cmd_re     = 1'b0;
    cmd_we     = 1'b0;
    tbl_we     = 1'b0;
    cmd_raddr  = pixel_index_i[PixAw-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !s1_v_q && !s2_v_q;
        cmd_re     = accept && cmd_op_ok &&
                     (op_e'(op_i) == OP_SET_MODE || op_e'(op_i) == OP_SET_INDEX);
        tbl_we     = accept && (op_e'(op_i) == OP_WR_TABLE) &&
                     ({1'b0, color_index_i} < 6'(TABLE_ENTRIES));
      end
      ST_MERGE: cmd_we = 1'b1;
      ST_FRAME: begin
        issue     = adv;
        cmd_re    = adv;
        cmd_raddr = cnt_q[PixAw-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      if (frame_go) begin
        cnt_q <= '0;
        n_q   <= count_eff;
      end else if (issue) begin
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  // item fields, held for the merge and for the whole frame
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      pix_q   <= pixel_index_i[PixAw-1:0];
      mode_q  <= mode_bits_i;
      idx_q   <= color_index_i;
      phase_q <= phase_i;
      ffd_q   <= fade_fast_dec_i;
      fsd_q   <= fade_slow_dec_i;
      bfo_q   <= blink_fast_on_i;
      bso_q   <= blink_slow_on_i;
    end
  end

  // ---------------- command memory ----------------
  assign cmd_eff    = cmd_rvld_q ? cmd_rdata_q : '0;
  assign cmd_merged = (op_q == OP_SET_MODE) ? {mode_q, cmd_eff[4:0]} : {cmd_eff[7:5], idx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_we) begin
      cmd_mem[pix_q] <= cmd_merged;
    end
    if (cmd_re) begin
      cmd_rdata_q <= cmd_mem[cmd_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q  <= '0;
      cmd_rvld_q <= 1'b0;
    end else begin
      if (cmd_we) begin
        cmd_vld_q[pix_q] <= 1'b1;
      end
      if (cmd_re) begin
        cmd_rvld_q <= cmd_vld_q[cmd_raddr];
      end
    end
  end

  // ---------------- color table ----------------
  assign tbl_raddr = cmd_eff[TblAw-1:0];

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[color_index_i[TblAw-1:0]] <= color_i;
    end
    if (adv) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q  <= '0;
      tbl_rvld_q <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_q[color_index_i[TblAw-1:0]] <= 1'b1;
      end
      if (adv) begin
        tbl_rvld_q <= tbl_vld_q[tbl_raddr];
      end
    end
  end

  // ---------------- stage 1: mode decode and fade factor ----------------
  always_comb begin
    logic [6:0] sub, inc, diff;
    logic       fast, dec;
    fast = cmd_eff[5];
    dec  = fast ? ffd_q : fsd_q;
    sub  = fast ? {1'b0, phase_q[3:0], 2'b00} : {1'b0, phase_q};
    inc  = fast ? {({1'b0, phase_q[3:0]} + 5'd1), 2'b00} : ({1'b0, phase_q} + 7'd1);
    diff = max_state_q - sub;
    if (dec) begin
      if (max_state_q < sub) begin
        s1_factor = '0;
      end else if (diff > MAX_FACTOR) begin
        s1_factor = MAX_FACTOR;
      end else begin
        s1_factor = diff;
      end
    end else begin
      s1_factor = inc;
    end

    if (cmd_eff[7]) begin
      s1_kind = KIND_PASS;
    end else if (cmd_eff[6]) begin
      s1_kind = KIND_SCALE;
    end else if (fast) begin
      s1_kind = bfo_q ? KIND_PASS : KIND_BLACK;
    end else begin
      s1_kind = bso_q ? KIND_PASS : KIND_BLACK;
    end
  end

  // ---------------- stage 2: color select and scale ----------------
  always_comb begin
    if (s2_oor_q) begin
      base_color = '0;
    end else if (tbl_rvld_q) begin
      base_color = tbl_rdata_q;
    end else begin
      base_color = s2_zero_q ? WHITE : '0;
    end
    case (s2_kind_q)
      KIND_PASS:  out_word_d = base_color;
      KIND_BLACK: out_word_d = '0;
      KIND_SCALE: out_word_d = {scale_chan(base_color[23:16], s2_factor_q),
                                scale_chan(base_color[15:8],  s2_factor_q),
                                scale_chan(base_color[7:0],   s2_factor_q)};
      default:    out_word_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q   <= issue && cnt_last;
      s2_last_q   <= s1_last_q;
      s2_kind_q   <= s1_kind;
      s2_factor_q <= s1_factor;
      s2_oor_q    <= ({1'b0, cmd_eff[4:0]} >= 6'(TABLE_ENTRIES));
      s2_zero_q   <= (cmd_eff[4:0] == 5'd0);
      out_word_q  <= out_word_d;
      out_last_q  <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= issue;
      s2_v_q      <= s1_v_q;
      out_valid_q <= s2_v_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_word_o = out_word_q;
  assign last_o       = out_last_q;

endmodule

[bench/led_frame_color_generator_tb.sv]
// Self-checking bench for the LED frame color generator: directed and random command words.
module led_frame_color_generator_tb;
  import lfcg_pkg::*;

  localparam int NUM_PIXELS   = 64;
  localparam int NUM_ENTRIES  = 32;
  localparam int GAIN_UNITY   = 32;
  localparam int GAIN_CEIL    = 64;
  localparam int GAIN_SHIFT   = 5;
  localparam int MODE_ON_BIT  = 7;
  localparam int MODE_FADE_BIT = 6;
  localparam int MODE_FAST_BIT = 5;
  localparam logic [2:0] MODE_STEADY = 3'b100;
  localparam logic [1:0] CFG_SPARE   = 2'd3;
  localparam int MAX_WAIT = 17;
  localparam int SETTLE   = 8;
  localparam int LIMIT    = 800000;

  typedef struct {
    op_e         op;
    logic [5:0]  pix;
    logic [2:0]  mode;
    logic [4:0]  cidx;
    logic [23:0] color;
    logic [5:0]  phase;
    logic        ffd;
    logic        fsd;
    logic        bfo;
    logic        bso;
  } led_req_t;

  typedef struct {
    logic [23:0] word;
    logic        last;
  } pix_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [6:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [5:0]  pixel_index_i;
  logic [2:0]  mode_bits_i;
  logic [4:0]  color_index_i;
  logic [23:0] color_i;
  logic [5:0]  phase_i;
  logic        fade_fast_dec_i;
  logic        fade_slow_dec_i;
  logic        blink_fast_on_i;
  logic        blink_slow_on_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [23:0] pixel_word_o;
  logic        last_o;

  // predictor state
  logic [7:0]  cmd_store [NUM_PIXELS];
  logic [23:0] color_lut [NUM_ENTRIES];
  logic [6:0]  pixel_count_q;
  logic        enable_q;
  logic [6:0]  max_state_q;
  pix_result_t pending_words [$];

  int  errors      = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  no_idle     = 1'b0;

  led_frame_color_generator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .pixel_index_i  (pixel_index_i),
    .mode_bits_i    (mode_bits_i),
    .color_index_i  (color_index_i),
    .color_i        (color_i),
    .phase_i        (phase_i),
    .fade_fast_dec_i(fade_fast_dec_i),
    .fade_slow_dec_i(fade_slow_dec_i),
    .blink_fast_on_i(blink_fast_on_i),
    .blink_slow_on_i(blink_slow_on_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_word_o   (pixel_word_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void reset_model();
    foreach (cmd_store[i]) cmd_store[i] = '0;
    foreach (color_lut[i]) color_lut[i] = '0;
    color_lut[0]  = WHITE;
    pixel_count_q = '0;
    enable_q      = 1'b0;
    max_state_q   = MAX_STATE_RESET;
  endfunction

  // gain clamps to 0..64; unity passes through, else channel*gain>>5 clipped to a byte
  function automatic logic [23:0] fade_scale(input logic [23:0] grb, input int gain);
    logic [23:0] res;
    int          ch;
    res = '0;
    if (gain < 0) gain = 0;
    if (gain > GAIN_CEIL) gain = GAIN_CEIL;
    if (gain == GAIN_UNITY) return grb;
    for (int k = 0; k < 3; k++) begin
      ch = (int'(grb[8*k +: 8]) * gain) >>> GAIN_SHIFT;
      if (ch > 255) ch = 255;
      res[8*k +: 8] = ch[7:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] shade_pixel(input logic [7:0] cmd, input led_req_t r);
    logic [23:0] grb;
    int          gain;
    grb = color_lut[cmd[4:0]];
    if (cmd[MODE_ON_BIT]) return grb;
    if (cmd[MODE_FADE_BIT]) begin
      if (cmd[MODE_FAST_BIT])
        gain = r.ffd ? int'(max_state_q) - 4 * int'(r.phase[3:0])
                     : 4 * (int'(r.phase[3:0]) + 1);
      else
        gain = r.fsd ? int'(max_state_q) - int'(r.phase) : int'(r.phase) + 1;
      return fade_scale(grb, gain);
    end
    if (cmd[MODE_FAST_BIT]) return r.bfo ? grb : '0;
    return r.bso ? grb : '0;
  endfunction

  function automatic void apply_request(input led_req_t r);
    int          n;
    pix_result_t res;
    case (r.op)
      OP_SET_MODE:  cmd_store[r.pix][7:5] = r.mode;
      OP_SET_INDEX: cmd_store[r.pix][4:0] = r.cidx;
      OP_WR_TABLE:  color_lut[r.cidx] = r.color;
      OP_FRAME: begin
        if (enable_q) begin
          n = (int'(pixel_count_q) > NUM_PIXELS) ? NUM_PIXELS : int'(pixel_count_q);
          for (int i = 0; i < n; i++) begin
            res.word = shade_pixel(cmd_store[i], r);
            res.last = (i == n - 1);
            pending_words.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic led_req_t noise_req();
    led_req_t r;
    r.op    = op_e'($urandom_range(0, 3));
    r.pix   = 6'($urandom);
    r.mode  = 3'($urandom);
    r.cidx  = 5'($urandom);
    r.color = 24'($urandom);
    r.phase = 6'($urandom);
    r.ffd   = 1'($urandom);
    r.fsd   = 1'($urandom);
    r.bfo   = 1'($urandom);
    r.bso   = 1'($urandom);
    return r;
  endfunction

  task automatic send_word(input led_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i            = r.op;
    pixel_index_i   = r.pix;
    mode_bits_i     = r.mode;
    color_index_i   = r.cidx;
    color_i         = r.color;
    phase_i         = r.phase;
    fade_fast_dec_i = r.ffd;
    fade_slow_dec_i = r.fsd;
    blink_fast_on_i = r.bfo;
    blink_slow_on_i = r.bso;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(r);
  endtask

  // drain all expected words, then give trailing writes time to land
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_PIXEL_COUNT: pixel_count_q = val;
      CFG_ENABLE:      enable_q = val[0];
      CFG_MAX_STATE:   max_state_q = val;
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic [5:0] pix, input logic [2:0] mode);
    led_req_t r;
    r = noise_req();
    r.op = OP_SET_MODE;
    r.pix = pix;
    r.mode = mode;
    send_word(r);
  endtask

  task automatic set_index(input logic [5:0] pix, input logic [4:0] cidx);
    led_req_t r;
    r = noise_req();
    r.op = OP_SET_INDEX;
    r.pix = pix;
    r.cidx = cidx;
    send_word(r);
  endtask

  task automatic set_color(input logic [4:0] cidx, input logic [23:0] color);
    led_req_t r;
    r = noise_req();
    r.op = OP_WR_TABLE;
    r.cidx = cidx;
    r.color = color;
    send_word(r);
  endtask

  task automatic run_frame(input logic [5:0] phase, input logic ffd, input logic fsd,
                           input logic bfo, input logic bso);
    led_req_t r;
    r = noise_req();
    r.op = OP_FRAME;
    r.phase = phase;
    r.ffd = ffd;
    r.fsd = fsd;
    r.bfo = bfo;
    r.bso = bso;
    send_word(r);
  endtask

  // out of reset: disabled frames are silent, pixels are slow blink on white
  task automatic test_reset_state();
    run_frame(6'd0, 1'b0, 1'b0, 1'b1, 1'b1);
    wait_quiet();
    cfg_write(CFG_PIXEL_COUNT, 7'd4);
    cfg_write(CFG_ENABLE, 7'd1);
    run_frame(6'd9, 1'b0, 1'b0, 1'b0, 1'b1);
    run_frame(6'd9, 1'b1, 1'b1, 1'b1, 1'b0);
  endtask

  // all eight mode encodings side by side across blink and fade inputs
  task automatic test_mode_decode();
    wait_quiet();
    cfg_write(CFG_PIXEL_COUNT, 7'd8);
    for (int i = 0; i < 8; i++) set_mode(6'(i), 3'(i));
    set_color(5'd0, 24'h80_FF_01);
    set_color(5'd31, 24'hFF_FF_FF);
    set_index(6'd7, 5'd31);
    run_frame(6'd0, 1'b0, 1'b0, 1'b1, 1'b1);
    run_frame(6'd63, 1'b1, 1'b1, 1'b0, 1'b0);
    run_frame(6'd7, 1'b0, 1'b1, 1'b1, 1'b0);  // fast brightening lands on unity
    run_frame(6'd31, 1'b1, 1'b0, 1'b0, 1'b1); // fast darkening goes negative
  endtask

  task automatic test_config_extremes();
    wait_quiet();
    cfg_write(CFG_MAX_STATE, 7'd127);
    run_frame(6'd0, 1'b1, 1'b1, 1'b0, 1'b0);  // gain clamps high, channels saturate
    wait_quiet();
    cfg_write(CFG_MAX_STATE, 7'd0);
    run_frame(6'd63, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_quiet();
    cfg_write(CFG_MAX_STATE, 7'd64);
    cfg_write(CFG_PIXEL_COUNT, 7'd127);       // clipped to the full array
    set_mode(6'd63, MODE_STEADY);
    set_index(6'd63, 5'd31);
    run_frame(6'd40, 1'b0, 1'b1, 1'b1, 1'b0);
    wait_quiet();
    cfg_write(CFG_PIXEL_COUNT, 7'd0);
    run_frame(6'd5, 1'b0, 1'b0, 1'b1, 1'b1);
    wait_quiet();
    cfg_write(CFG_PIXEL_COUNT, 7'd1);
    cfg_write(CFG_SPARE, 7'h7F);
    cfg_write(CFG_ENABLE, 7'h7E);             // only bit 0 counts
    run_frame(6'd5, 1'b0, 1'b0, 1'b1, 1'b1);
    wait_quiet();
    cfg_write(CFG_ENABLE, 7'd1);
    run_frame(6'd33, 1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic random_batch(input int count, input bit quiet);
    led_req_t   r;
    logic [6:0] pc;
    logic [6:0] data;
    int         sel;
    int         span;
    wait_quiet();
    sel = $urandom_range(0, 9);
    if (sel == 0) pc = 7'd64;
    else if (sel == 1) pc = 7'($urandom_range(65, 127));
    else pc = 7'($urandom_range(0, 16));
    cfg_write(CFG_PIXEL_COUNT, pc);
    cfg_write(CFG_MAX_STATE, 7'($urandom_range(0, 127)));
    data = 7'($urandom);
    if ($urandom_range(0, 9) != 0) data[0] = 1'b1;
    cfg_write(CFG_ENABLE, data);
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, 7'($urandom));
    span = (int'(pc) > NUM_PIXELS) ? NUM_PIXELS : int'(pc);
    no_idle = quiet;
    repeat (count) begin
      r = noise_req();
      sel = $urandom_range(0, 9);
      if (sel < 3) r.op = OP_FRAME;
      else if (sel < 5) r.op = OP_SET_MODE;
      else if (sel < 7) r.op = OP_SET_INDEX;
      else r.op = OP_WR_TABLE;
      // mostly touch pixels that the frame will show
      if (span > 0 && $urandom_range(0, 3) != 0) r.pix = 6'($urandom_range(0, span - 1));
      send_word(r);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    for (int b = 0; b < 5; b++) random_batch(16, b == 2);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_words
    pix_result_t want;
    cycle_count++;
    if (out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got %h last %b",
                 $time, pixel_word_o, last_o);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (pixel_word_o !== want.word) begin
          $display("%0t: pixel_word expected %h got %h", $time, want.word, pixel_word_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, last_o);
          errors++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    op_i            = '0;
    pixel_index_i   = '0;
    mode_bits_i     = '0;
    color_index_i   = '0;
    color_i         = '0;
    phase_i         = '0;
    fade_fast_dec_i = 1'b0;
    fade_slow_dec_i = 1'b0;
    blink_fast_on_i = 1'b0;
    blink_slow_on_i = 1'b0;
    reset_model();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_mode_decode();
    test_config_extremes();
    test_random();

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lfcg_pkg.sv
rtl/core/led_frame_color_generator.sv
bench/led_frame_color_generator_tb.sv
